FILE: rtl/core/frsq_pkg.sv
// Shared types and constants of the binary16 reciprocal square root block.
`default_nettype none
package frsq_pkg;

    localparam logic [15:0] QNAN_BITS = 16'h7E00;
    localparam logic [15:0] PINF_BITS = 16'h7C00;
    localparam logic [15:0] NINF_BITS = 16'hFC00;
    localparam logic [15:0] ZERO_BITS = 16'h0000;

    // Root digits: 2^18 / sqrt(m) lies in (2^12, 2^13].
    localparam int Z_BITS = 14;
    localparam logic [36:0] ROOT_ONE = 37'h10_0000_0000;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] RM_NEAREST = 2'd0;
    localparam logic [1:0] RM_ZERO    = 2'd1;
    localparam logic [1:0] RM_UP      = 2'd2;
    localparam logic [1:0] RM_DOWN    = 2'd3;

    typedef struct packed {
        logic        special;
        logic [15:0] sp_result;
        logic        inv;
        logic        dz;
        logic [11:0] m;
        logic [4:0]  ebase;
    } frsq_item_t;

    typedef struct packed {
        frsq_item_t        item;
        logic [Z_BITS-1:0] z;
        logic [25:0]       a;
        logic [36:0]       r;
    } frsq_stage_t;

    // One root digit: try bit b, keep residual r = 2^36 - z^2*m and a = z*m.
    function automatic frsq_stage_t frsq_step(frsq_stage_t s, logic [3:0] b);
        logic [39:0] mb;
        logic [39:0] t;
        frsq_stage_t o;
        mb = 40'(s.item.m) << b;
        t  = ((40'(s.a) << 1) + mb) << b;
        o  = s;
        if (40'(s.r) >= t)
        begin
            o.r = 37'(40'(s.r) - t);
            o.z = s.z | (Z_BITS'(1) << b);
            o.a = s.a + 26'(mb);
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/frsq_front.sv
// Front end: classify the operand and normalize its significand.
`default_nettype none
module frsq_front
    import frsq_pkg::*;
(
    input  wire logic [15:0] x_bits,
    output frsq_item_t       item
);

    logic              sign;
    logic [4:0]        ex;
    logic [9:0]        fr;
    logic [3:0]        msb;
    logic [3:0]        n;
    logic [10:0]       m11;
    logic signed [6:0] kk;
    logic signed [6:0] ke;
    logic signed [6:0] eb;

    always_comb
    begin
        sign = x_bits[15];
        ex   = x_bits[14:10];
        fr   = x_bits[9:0];

        msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (fr[i])
            begin
                msb = 4'(i);
            end
        end
        n = 4'd10 - msb;

        if (ex == 5'd0)
        begin
            m11 = 11'(fr) << n;
            kk  = -7'sd24 - $signed({3'b000, n});
        end
        else
        begin
            m11 = {1'b1, fr};
            kk  = $signed({2'b00, ex}) - 7'sd25;
        end

        // Make the exponent even.
        if (kk[0])
        begin
            item.m = {m11, 1'b0};
            ke     = kk - 7'sd1;
        end
        else
        begin
            item.m = {1'b0, m11};
            ke     = kk;
        end
        eb         = 7'sd9 - (ke >>> 1);
        item.ebase = eb[4:0];

        item.special   = 1'b1;
        item.inv       = 1'b0;
        item.dz        = 1'b0;
        item.sp_result = QNAN_BITS;
        if (ex == 5'd31 && fr != 10'd0)
        begin
            item.inv = ~fr[9];
        end
        else if (ex == 5'd0 && fr == 10'd0)
        begin
            item.sp_result = sign ? NINF_BITS : PINF_BITS;
            item.dz        = 1'b1;
        end
        else if (sign)
        begin
            item.inv = 1'b1;
        end
        else if (ex == 5'd31)
        begin
            item.sp_result = ZERO_BITS;
        end
        else
        begin
            item.special = 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/frsq_queue.sv
// Two-entry item queue between the front end and the root pipeline.
`default_nettype none
module frsq_queue
    import frsq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  frsq_item_t      push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output frsq_item_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    frsq_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("queue pop while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + (PTR_W+1)'($past(push)) - (PTR_W+1)'($past(pop)))
        else $error("queue count out of step");

endmodule
`default_nettype wire

FILE: rtl/core/frsq_back.sv
// Back end: digit-by-digit root pipeline, final rounding and output register.
`default_nettype none
module frsq_back
    import frsq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  mode,
    input  wire logic        q_not_empty,
    input  frsq_item_t       q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_bits,
    output logic             invalid_flag,
    output logic             div_by_zero_flag
);

    frsq_stage_t stage_reg [Z_BITS];
    logic        valid_reg [Z_BITS];
    frsq_stage_t init;
    logic        advance;

    logic        out_valid_reg;
    logic [15:0] result_reg;
    logic        inv_reg;
    logic        dz_reg;

    frsq_stage_t last;
    logic [10:0] sig;
    logic        rb;
    logic        st;
    logic        up;
    logic [11:0] sum;
    logic [4:0]  e;
    logic [15:0] res_next;

    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && q_not_empty;

    always_comb
    begin
        init.item = q_head;
        init.z    = '0;
        init.a    = '0;
        init.r    = ROOT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= frsq_step(init, 4'(Z_BITS-1));
        end
    end

    for (genvar j = 1; j < Z_BITS; j++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[j] <= frsq_step(stage_reg[j-1], 4'(Z_BITS-1-j));
            end
        end
    end

    // Round once: 11 significand bits, one round bit, sticky from the rest.
    always_comb
    begin
        last = stage_reg[Z_BITS-1];
        sig  = last.z[12:2];
        rb   = last.z[1];
        st   = last.z[0] | (last.r != '0);
        case (mode)
            RM_NEAREST: up = rb && (st || sig[0]);
            RM_UP:      up = rb || st;
            RM_ZERO:    up = 1'b0;
            RM_DOWN:    up = 1'b0;
            default:    up = 1'b0;
        endcase
        sum = {1'b0, sig} + 12'(up);
        if (last.z[13] || sum[11])
        begin
            e        = last.item.ebase + 5'd1;
            res_next = {1'b0, e, 10'd0};
        end
        else
        begin
            e        = last.item.ebase;
            res_next = {1'b0, e, sum[9:0]};
        end
        if (last.item.special)
        begin
            res_next = last.item.sp_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_reg[Z_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= res_next;
            inv_reg    <= last.item.inv;
            dz_reg     <= last.item.dz;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_bits      = result_reg;
    assign invalid_flag     = inv_reg;
    assign div_by_zero_flag = dz_reg;

endmodule
`default_nettype wire

FILE: rtl/core/fp16_reciprocal_sqrt.sv
// Top level of the binary16 reciprocal square root unit.
// fp16_reciprocal_sqrt returns 1/sqrt(x) for one binary16 operand per item,
// correctly rounded once in the mode held in the configuration register
// (0 nearest-even, 1 toward zero, 2 toward plus infinity, 3 toward minus
// infinity; reset 0). Subnormal operands are supported. Zero gives an
// infinity of the same sign with the divide-by-zero flag, +inf gives +0,
// NaNs and negative nonzero operands give the quiet NaN 0x7E00, with the
// invalid flag for signaling NaNs and negative operands. The unit takes one
// item per cycle while the output is not stalled: the front end classifies
// and normalizes in the accepting cycle, a two-entry queue decouples it from
// a 14-stage root pipeline that retires one root bit per stage, and one
// output register follows rounding. The rate is set by the root pipeline,
// which advances whenever the output register is empty or being taken.
// Write the rounding mode only while idle.
`default_nettype none
module fp16_reciprocal_sqrt
    import frsq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] x_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_bits,
    output logic             invalid_flag,
    output logic             div_by_zero_flag
);

    logic [1:0]  mode_reg;
    frsq_item_t  front_item;
    frsq_item_t  q_head;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;

    // The mode register always takes a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RM_NEAREST;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Accept an item whenever the queue has room.
    assign in_ready = !q_full;

    frsq_front u_front (
        .x_bits (x_bits),
        .item   (front_item)
    );

    frsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    frsq_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .mode             (mode_reg),
        .q_not_empty      (q_not_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_bits      (result_bits),
        .invalid_flag     (invalid_flag),
        .div_by_zero_flag (div_by_zero_flag)
    );

endmodule
`default_nettype wire
